FILE: src/rbp_pkg.sv
// shared types, constants and helpers of the ray box nearest hit picker
`default_nettype none
package rbp_pkg;
    localparam int DEF_MAX_BOXES   = 1024;
    localparam int DEF_COORD_WIDTH = 32;
    localparam int FRAC_BITS       = 16;
    localparam int MAXD_WIDTH      = 31;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int INDEX_WIDTH     = 10;
    localparam int FACE_WIDTH      = 3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5,
        CFG_MAX_DIST = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic load;
        logic start_lo;
        logic start_hi;
        logic zero_reject;
        logic slab;
        logic next_axis;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic will_test;
        logic dir_zero;
        logic outside;
        logic slab_reject;
        logic axis_last;
        logic div_done;
        logic last;
        logic out_full;
    } t_dp_status;

    // face through the lower plane of an axis: 1, 3, 5
    function automatic logic [FACE_WIDTH-1:0] lo_face(input logic [1:0] axis);
        lo_face = {axis, 1'b1};
    endfunction

    // face through the upper plane of an axis: 0, 2, 4
    function automatic logic [FACE_WIDTH-1:0] hi_face(input logic [1:0] axis);
        hi_face = {axis, 1'b0};
    endfunction
endpackage
`default_nettype wire

FILE: src/rbp_divider.sv
// iterative restoring divider for the slab parameter, one quotient bit per cycle
`default_nettype none
module rbp_divider
    import rbp_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [COORD_WIDTH:0]   i_num,
    input  wire logic signed [COORD_WIDTH-1:0] i_den,
    output logic                               o_done,
    output logic signed [COORD_WIDTH-1:0]      o_t
);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);

    logic                 r_busy, r_fin, r_done, r_neg;
    logic [CNT_W-1:0]     r_cnt;
    logic [DW-1:0]        r_dvd;
    logic [CW-1:0]        r_rem, r_ud;
    logic signed [CW-1:0] r_t;

    logic [CW:0]   w_num_mag, w_den_mag, w_shift, w_diff;
    logic          w_qbit;
    logic [CW-2:0] w_qmag;
    logic [CW-1:0] w_qext;

    assign w_num_mag = i_num[CW] ? -i_num : i_num;
    assign w_den_mag = i_den[CW-1] ? -{i_den[CW-1], i_den} : {i_den[CW-1], i_den};
    assign w_shift   = {r_rem, r_dvd[DW-1]};
    assign w_diff    = w_shift - {1'b0, r_ud};
    assign w_qbit    = (w_shift >= {1'b0, r_ud});
    // saturate to the largest positive value
    assign w_qmag    = (|r_dvd[DW-1:CW-1]) ? {(CW-1){1'b1}} : r_dvd[CW-2:0];
    assign w_qext    = {1'b0, w_qmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
                r_neg  <= i_num[CW] ^ i_den[CW-1];
                r_dvd  <= {w_num_mag[CW-1:0], {FRAC_BITS{1'b0}}};
                r_ud   <= w_den_mag[CW-1:0];
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_qbit ? w_diff[CW-1:0] : w_shift[CW-1:0];
                r_dvd <= {r_dvd[DW-2:0], w_qbit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (r_fin) begin
                r_t <= r_neg ? -$signed(w_qext) : $signed(w_qext);
            end
        end
    end

    assign o_done = r_done;
    assign o_t    = r_t;
endmodule
`default_nettype wire

FILE: src/rbp_datapath.sv
// datapath: ray registers, box slab arithmetic, running best hit and result register
`default_nettype none
module rbp_datapath
    import rbp_pkg::*;
#(
    parameter int MAX_BOXES   = DEF_MAX_BOXES,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int CFG_W       = (COORD_WIDTH > MAXD_WIDTH) ? COORD_WIDTH : MAXD_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0]      i_cfg_index,
    input  wire logic [CFG_W-1:0]              i_cfg_data,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_min_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_min_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_min_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_max_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_max_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_max_z,
    input  wire logic                          i_box_hidden,
    input  wire logic                          i_box_last,
    input  wire t_dp_cmd                       i_cmd,
    output t_dp_status                         o_status,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_hit_found,
    output logic [INDEX_WIDTH-1:0]             o_hit_index,
    output logic [FACE_WIDTH-1:0]              o_hit_face
);
    localparam int CW    = COORD_WIDTH;
    localparam int BD_W  = (CW - 1 > MAXD_WIDTH) ? CW - 1 : MAXD_WIDTH;
    localparam int IDX_W = $clog2(MAX_BOXES + 1);

    logic signed [CW-1:0] r_org [3];
    logic signed [CW-1:0] r_dir [3];
    logic [MAXD_WIDTH-1:0] r_maxd;
    logic signed [CW-1:0] r_lo [3];
    logic signed [CW-1:0] r_hi [3];
    logic r_last, r_tested, r_reject, r_entered, r_which;
    logic [1:0] r_axis;
    logic signed [CW-1:0] r_tmin, r_tmax, r_ta, r_tb;
    logic [FACE_WIDTH-1:0] r_eface;
    logic [IDX_W-1:0] r_idx, r_count, r_best_idx;
    logic [BD_W-1:0] r_best_dist;
    logic [FACE_WIDTH-1:0] r_best_face;
    logic r_any_hit;
    logic r_out_valid, r_out_found;
    logic [INDEX_WIDTH-1:0] r_out_idx;
    logic [FACE_WIDTH-1:0] r_out_face;

    logic signed [CW-1:0] w_o, w_d, w_lo, w_hi, w_t;
    logic signed [CW:0] w_num_lo, w_num_hi, w_num;
    logic w_div_done;
    logic signed [CW-1:0] w_near, w_far, n_tmin, n_tmax;
    logic [FACE_WIDTH-1:0] w_nface, n_eface;
    logic n_entered, w_hit, w_any;
    logic [BD_W-1:0] w_tmin_ext;
    logic [IDX_W-1:0] w_bidx;
    logic [FACE_WIDTH-1:0] w_bface;
    t_cfg_reg w_cfg;

    assign w_o  = r_org[r_axis];
    assign w_d  = r_dir[r_axis];
    assign w_lo = r_lo[r_axis];
    assign w_hi = r_hi[r_axis];
    assign w_num_lo = {w_lo[CW-1], w_lo} - {w_o[CW-1], w_o};
    assign w_num_hi = {w_hi[CW-1], w_hi} - {w_o[CW-1], w_o};
    assign w_num    = i_cmd.start_hi ? w_num_hi : w_num_lo;

    rbp_divider #(.COORD_WIDTH(COORD_WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_lo | i_cmd.start_hi),
        .i_num   (w_num),
        .i_den   (w_d),
        .o_done  (w_div_done),
        .o_t     (w_t)
    );

    // order the two plane crossings, swapping faces with them
    always_comb begin
        if (r_ta > r_tb) begin
            w_near  = r_tb;
            w_far   = r_ta;
            w_nface = hi_face(r_axis);
        end else begin
            w_near  = r_ta;
            w_far   = r_tb;
            w_nface = lo_face(r_axis);
        end
        n_tmin    = r_tmin;
        n_eface   = r_eface;
        n_entered = r_entered;
        if (w_near > r_tmin) begin
            n_tmin    = w_near;
            n_eface   = w_nface;
            n_entered = 1'b1;
        end
        n_tmax = (w_far < r_tmax) ? w_far : r_tmax;
    end

    assign w_tmin_ext = BD_W'(r_tmin[CW-2:0]);
    assign w_hit   = r_tested && !r_reject && !r_tmax[CW-1] && r_entered
                     && (w_tmin_ext <= r_best_dist);
    assign w_any   = w_hit | r_any_hit;
    assign w_bidx  = w_hit ? r_idx : r_best_idx;
    assign w_bface = w_hit ? r_eface : r_best_face;
    assign w_cfg   = t_cfg_reg'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= '0;
                r_dir[i] <= '0;
            end
            r_maxd      <= {MAXD_WIDTH{1'b1}};
            r_best_dist <= BD_W'({MAXD_WIDTH{1'b1}});
            r_best_idx  <= '0;
            r_best_face <= '0;
            r_any_hit   <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !(i_cmd.commit && r_last)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_lo[0]   <= i_box_min_x;
                r_lo[1]   <= i_box_min_y;
                r_lo[2]   <= i_box_min_z;
                r_hi[0]   <= i_box_max_x;
                r_hi[1]   <= i_box_max_y;
                r_hi[2]   <= i_box_max_z;
                r_last    <= i_box_last;
                r_tested  <= o_status.will_test;
                r_reject  <= 1'b0;
                r_entered <= 1'b0;
                r_eface   <= '0;
                r_axis    <= '0;
                r_tmin    <= '0;
                r_tmax    <= {1'b0, {(CW-1){1'b1}}};
                r_idx     <= r_count;
                if (r_count < IDX_W'(MAX_BOXES)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.start_lo | i_cmd.start_hi) begin
                r_which <= i_cmd.start_hi;
            end
            if (w_div_done) begin
                if (r_which) begin
                    r_tb <= w_t;
                end else begin
                    r_ta <= w_t;
                end
            end
            if (i_cmd.zero_reject) begin
                r_reject <= 1'b1;
            end
            if (i_cmd.slab) begin
                r_tmin    <= n_tmin;
                r_tmax    <= n_tmax;
                r_eface   <= n_eface;
                r_entered <= n_entered;
                r_reject  <= o_status.slab_reject;
            end
            if (i_cmd.next_axis) begin
                r_axis <= r_axis + 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_last) begin
                    r_out_valid <= 1'b1;
                    r_out_found <= w_any;
                    r_out_idx   <= w_any ? INDEX_WIDTH'(w_bidx) : '0;
                    r_out_face  <= w_any ? w_bface : '0;
                    r_best_dist <= BD_W'(r_maxd);
                    r_best_idx  <= '0;
                    r_best_face <= '0;
                    r_any_hit   <= 1'b0;
                    r_count     <= '0;
                end else begin
                    if (w_hit) begin
                        r_best_dist <= w_tmin_ext;
                    end
                    r_best_idx  <= w_bidx;
                    r_best_face <= w_bface;
                    r_any_hit   <= w_any;
                end
            end
            if (i_cfg_we) begin
                case (w_cfg)
                    CFG_ORIGIN_X: r_org[0] <= i_cfg_data[CW-1:0];
                    CFG_ORIGIN_Y: r_org[1] <= i_cfg_data[CW-1:0];
                    CFG_ORIGIN_Z: r_org[2] <= i_cfg_data[CW-1:0];
                    CFG_DIR_X:    r_dir[0] <= i_cfg_data[CW-1:0];
                    CFG_DIR_Y:    r_dir[1] <= i_cfg_data[CW-1:0];
                    CFG_DIR_Z:    r_dir[2] <= i_cfg_data[CW-1:0];
                    CFG_MAX_DIST: begin
                        r_maxd <= i_cfg_data[MAXD_WIDTH-1:0];
                        if (r_count == '0) begin
                            r_best_dist <= BD_W'(i_cfg_data[MAXD_WIDTH-1:0]);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_status.will_test   = !i_box_hidden && (r_count < IDX_W'(MAX_BOXES));
        o_status.dir_zero    = (w_d == '0);
        o_status.outside     = (w_o < w_lo) || (w_o > w_hi);
        o_status.slab_reject = (n_tmin > n_tmax);
        o_status.axis_last   = (r_axis == 2'd2);
        o_status.div_done    = w_div_done;
        o_status.last        = r_last;
        o_status.out_full    = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_hit_found = r_out_found;
    assign o_hit_index = r_out_idx;
    assign o_hit_face  = r_out_face;
endmodule
`default_nettype wire

FILE: src/rbp_ctrl.sv
// controller: sequences the per-axis slab test of one box at a time
`default_nettype none
module rbp_ctrl
    import rbp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);
    typedef enum logic [2:0] {
        S_IDLE, S_AXIS, S_DIV_LO, S_DIV_HI, S_SLAB, S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.will_test ? S_AXIS : S_DONE;
                end
            end
            S_AXIS: begin
                if (i_status.dir_zero) begin
                    if (i_status.outside) begin
                        o_cmd.zero_reject = 1'b1;
                        n_state           = S_DONE;
                    end else if (i_status.axis_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.next_axis = 1'b1;
                    end
                end else begin
                    o_cmd.start_lo = 1'b1;
                    n_state        = S_DIV_LO;
                end
            end
            S_DIV_LO: begin
                if (i_status.div_done) begin
                    o_cmd.start_hi = 1'b1;
                    n_state        = S_DIV_HI;
                end
            end
            S_DIV_HI: begin
                if (i_status.div_done) begin
                    n_state = S_SLAB;
                end
            end
            S_SLAB: begin
                o_cmd.slab = 1'b1;
                if (i_status.slab_reject || i_status.axis_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_axis = 1'b1;
                    n_state         = S_AXIS;
                end
            end
            S_DONE: begin
                if (!(i_status.last && i_status.out_full)) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);
endmodule
`default_nettype wire

FILE: src/ray_box_nearest_hit_picker.sv
// top level of the ray box nearest hit picker
//
// usage:
// - load the ray through the write port: origin x/y/z, direction x/y/z (signed
//   q16.16) and the largest accepted hit distance, while no box is in flight
// - stream boxes on the input channel (i_valid / o_stall), one transaction per box;
//   the box with i_box_last high closes the list
// - one result transaction per list leaves on the output channel (o_valid / i_stall):
//   hit flag, list position of the nearest hit and the face it is entered by
// - one box is worked on at a time; o_stall is high from acceptance until done
// - a hidden box, or one past the index limit, skips the axis tests and goes
//   straight to the commit step; a visible box runs two divisions through the
//   single bit-serial divider for each axis it tests with a nonzero direction,
//   while a zero direction axis needs no division
// - the result sits in an output register, so boxes of the next list are taken
//   while it waits; a further last box holds until that register drains
// - reset: ray registers clear, max distance goes to all ones, running best
//   cleared, no result pending
`default_nettype none
module ray_box_nearest_hit_picker
    import rbp_pkg::*;
#(
    parameter int MAX_BOXES   = DEF_MAX_BOXES,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int CFG_W       = (COORD_WIDTH > MAXD_WIDTH) ? COORD_WIDTH : MAXD_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0]      i_cfg_index,
    input  wire logic [CFG_W-1:0]              i_cfg_data,
    // box channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_min_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_min_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_min_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_max_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_max_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_box_max_z,
    input  wire logic                          i_box_hidden,
    input  wire logic                          i_box_last,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_hit_found,
    output logic [INDEX_WIDTH-1:0]             o_hit_index,
    output logic [FACE_WIDTH-1:0]              o_hit_face
);
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer: one box through axes and divisions
    rbp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    // arithmetic, running best and the result register
    rbp_datapath #(
        .MAX_BOXES   (MAX_BOXES),
        .COORD_WIDTH (COORD_WIDTH),
        .CFG_W       (CFG_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_box_min_x  (i_box_min_x),
        .i_box_min_y  (i_box_min_y),
        .i_box_min_z  (i_box_min_z),
        .i_box_max_x  (i_box_max_x),
        .i_box_max_y  (i_box_max_y),
        .i_box_max_z  (i_box_max_z),
        .i_box_hidden (i_box_hidden),
        .i_box_last   (i_box_last),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_out_stall  (i_stall),
        .o_out_valid  (o_valid),
        .o_hit_found  (o_hit_found),
        .o_hit_index  (o_hit_index),
        .o_hit_face   (o_hit_face)
    );
endmodule
`default_nettype wire

FILE: src/rbp_checker.sv
// port level checks of the ray box nearest hit picker, bound to the top level
`default_nettype none
module rbp_checker
    import rbp_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_valid,
    input wire logic                   i_stall,
    input wire logic                   o_hit_found,
    input wire logic [INDEX_WIDTH-1:0] o_hit_index,
    input wire logic [FACE_WIDTH-1:0]  o_hit_face
);
    // no result straight after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit_found)
            && $stable(o_hit_index) && $stable(o_hit_face))
        else $error("stalled result changed");

    // a miss reports index and face as zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit_found |-> o_hit_index == '0 && o_hit_face == '0)
        else $error("miss with nonzero index or face");

    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hit_face <= FACE_WIDTH'(5))
        else $error("face code out of range");
endmodule

bind ray_box_nearest_hit_picker rbp_checker u_rbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_hit_found (o_hit_found),
    .o_hit_index (o_hit_index),
    .o_hit_face  (o_hit_face)
);
`default_nettype wire
